// ===== src/dsag_pkg.sv =====
package dsag_pkg;

    // Board geometry. The square index field is six bits wide, so the lookup
    // table always has 64 slots; slots past the last board square stay empty.
    localparam int BOARD_WIDTH = 8;
    localparam int NUM_SQ      = BOARD_WIDTH * BOARD_WIDTH;
    localparam int SQUARE_W    = 6;
    localparam int SQ_SLOTS    = 2 ** SQUARE_W;
    localparam int BOARD_BITS  = 64;
    localparam int NUM_DIRS    = 4;

    typedef logic [BOARD_BITS-1:0]              t_board;
    typedef logic [SQUARE_W-1:0]                t_square;
    typedef logic [NUM_DIRS-1:0][BOARD_BITS-1:0] t_rays;
    typedef t_rays [SQ_SLOTS-1:0]               t_ray_tab;

    // Ray directions.
    localparam int DIR_NE = 0;
    localparam int DIR_SE = 1;
    localparam int DIR_SW = 2;
    localparam int DIR_NW = 3;

    // Rays that run toward row 0 walk to lower square indexes.
    localparam logic [NUM_DIRS-1:0] NORTH_DIRS = (NUM_DIRS'(1) << DIR_NE)
                                               | (NUM_DIRS'(1) << DIR_NW);

    localparam int COL_STEP [NUM_DIRS] = '{1, 1, -1, -1};
    localparam int ROW_STEP [NUM_DIRS] = '{-1, 1, 1, -1};

    // Squares that exist on the board.
    localparam t_board BOARD_MASK = (NUM_SQ >= BOARD_BITS) ? '1
                                  : ((t_board'(1) << NUM_SQ) - t_board'(1));

    // Empty-board diagonal rays for every origin square.
    function automatic t_ray_tab build_ray_tab();
        t_ray_tab tab;
        int       row;
        int       col;
        int       r;
        int       c;
        logic     stop;
        tab = '0;
        for (int sq = 0; sq < NUM_SQ; sq++) begin
            row = sq / BOARD_WIDTH;
            col = sq % BOARD_WIDTH;
            for (int d = 0; d < NUM_DIRS; d++) begin
                r    = row;
                c    = col;
                stop = 1'b0;
                for (int n = 0; n < BOARD_WIDTH; n++) begin
                    r = r + ROW_STEP[d];
                    c = c + COL_STEP[d];
                    if (r < 0 || r >= BOARD_WIDTH || c < 0 || c >= BOARD_WIDTH) begin
                        stop = 1'b1;
                    end
                    if (!stop) begin
                        tab[sq][d][r * BOARD_WIDTH + c] = 1'b1;
                    end
                end
            end
        end
        return tab;
    endfunction

    localparam t_ray_tab RAY_TAB = build_ray_tab();

    function automatic t_board lowest_bit(input t_board x);
        return x & (~x + t_board'(1));
    endfunction

    function automatic t_board reverse_bits(input t_board x);
        t_board y;
        for (int i = 0; i < BOARD_BITS; i++) begin
            y[i] = x[BOARD_BITS-1-i];
        end
        return y;
    endfunction

    function automatic t_board highest_bit(input t_board x);
        return reverse_bits(lowest_bit(reverse_bits(x)));
    endfunction

    // Stage payloads.
    typedef struct packed {
        t_rays  rays;
        t_rays  hits;
        t_board own;
    } t_ray_data;

    typedef struct packed {
        t_rays  rays;
        t_rays  blockers;
        t_board own;
    } t_blk_data;

endpackage

// ===== src/dsag_if.sv =====
interface dsag_req_if;
    logic                   valid;
    logic                   ready;
    dsag_pkg::t_square      square;
    dsag_pkg::t_board       occupied;
    dsag_pkg::t_board       own_pieces;

    modport source(output valid, output square, output occupied, output own_pieces,
                   input ready);
    modport sink(input valid, input square, input occupied, input own_pieces,
                 output ready);
endinterface

interface dsag_res_if;
    logic                   valid;
    logic                   ready;
    dsag_pkg::t_board       attacks;

    modport source(output valid, output attacks, input ready);
    modport sink(input valid, input attacks, output ready);
endinterface

// ===== src/dsag_ray_stage.sv =====
module dsag_ray_stage (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  dsag_pkg::t_square   i_square,
    input  dsag_pkg::t_board    i_occupied,
    input  dsag_pkg::t_board    i_own,
    output logic                o_valid,
    output dsag_pkg::t_ray_data o_data
);

    logic                r_valid;
    dsag_pkg::t_ray_data r_data;
    dsag_pkg::t_ray_data n_data;

    // Look up the empty-board rays and mark which of their squares are occupied.
    always_comb begin
        n_data.rays = dsag_pkg::RAY_TAB[i_square];
        for (int d = 0; d < dsag_pkg::NUM_DIRS; d++) begin
            n_data.hits[d] = n_data.rays[d] & i_occupied;
        end
        n_data.own = i_own;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// ===== src/dsag_blocker_stage.sv =====
module dsag_blocker_stage (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  dsag_pkg::t_ray_data i_data,
    output logic                o_valid,
    output dsag_pkg::t_blk_data o_data
);

    logic                r_valid;
    dsag_pkg::t_blk_data r_data;
    dsag_pkg::t_blk_data n_data;

    // The nearest blocker is the occupied ray square closest to the origin.
    always_comb begin
        n_data.rays = i_data.rays;
        n_data.own  = i_data.own;
        for (int d = 0; d < dsag_pkg::NUM_DIRS; d++) begin
            if (dsag_pkg::NORTH_DIRS[d]) begin
                n_data.blockers[d] = dsag_pkg::highest_bit(i_data.hits[d]);
            end else begin
                n_data.blockers[d] = dsag_pkg::lowest_bit(i_data.hits[d]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// ===== src/dsag_cut_stage.sv =====
module dsag_cut_stage (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  dsag_pkg::t_blk_data i_data,
    output logic                o_valid,
    output dsag_pkg::t_board    o_attacks
);

    logic             r_valid;
    dsag_pkg::t_board r_attacks;
    dsag_pkg::t_board n_attacks;
    dsag_pkg::t_rays  keep;

    // South rays keep the blocker and everything below it in index; north rays
    // keep the blocker and everything above it. An open ray is kept whole.
    always_comb begin
        n_attacks = '0;
        for (int d = 0; d < dsag_pkg::NUM_DIRS; d++) begin
            if (dsag_pkg::NORTH_DIRS[d]) begin
                if (i_data.blockers[d] == '0) begin
                    keep[d] = '1;
                end else begin
                    keep[d] = ~(i_data.blockers[d] - dsag_pkg::t_board'(1));
                end
            end else begin
                keep[d] = i_data.blockers[d] | (i_data.blockers[d] - dsag_pkg::t_board'(1));
            end
            n_attacks = n_attacks | (i_data.rays[d] & keep[d]);
        end
        n_attacks = n_attacks & ~i_data.own;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
        if (i_en) begin
            r_attacks <= n_attacks;
        end
    end

    assign o_valid   = r_valid;
    assign o_attacks = r_attacks;

endmodule

// ===== src/diagonal_slider_attack_generator_unit.sv =====
// Diagonal slider attack generator.
//
// A request on i_req carries an origin square, the occupancy of all pieces
// and the occupancy of the mover's own pieces. The block answers each request
// with one attack mask on o_res: every square a bishop on the origin reaches
// along the four diagonals, up to and including the first occupied square,
// with the mover's own squares cleared. An origin off the board gives zero.
//
// Throughput is one request per cycle while the receiver keeps taking
// results. An accepted request passes through the three register stages
// in order: ray lookup, nearest-blocker isolation, and ray cutting; the
// result is valid on o_res from the last of them.
//
// Reset (i_rst_n low, synchronous) empties every stage. When the receiver
// holds o_res.ready low the result stays put; the earlier stages keep filling
// the empty slots, and i_req.ready drops only once all three stages are full.
// Nothing is dropped or repeated across a stall.
module diagonal_slider_attack_generator_unit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    dsag_req_if.sink      i_req,
    dsag_res_if.source    o_res
);

    logic                s1_valid;
    logic                s2_valid;
    logic                s3_valid;
    logic                en1;
    logic                en2;
    logic                en3;
    dsag_pkg::t_ray_data s1_data;
    dsag_pkg::t_blk_data s2_data;

    // A stage moves when it is empty or when the stage after it moves.
    assign en3 = !s3_valid || o_res.ready;
    assign en2 = !s2_valid || en3;
    assign en1 = !s1_valid || en2;

    assign i_req.ready = en1;

    dsag_ray_stage u_ray (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en1),
        .i_valid    (i_req.valid),
        .i_square   (i_req.square),
        .i_occupied (i_req.occupied),
        .i_own      (i_req.own_pieces),
        .o_valid    (s1_valid),
        .o_data     (s1_data)
    );

    dsag_blocker_stage u_blocker (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en2),
        .i_valid (s1_valid),
        .i_data  (s1_data),
        .o_valid (s2_valid),
        .o_data  (s2_data)
    );

    dsag_cut_stage u_cut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (en3),
        .i_valid   (s2_valid),
        .i_data    (s2_data),
        .o_valid   (s3_valid),
        .o_attacks (o_res.attacks)
    );

    assign o_res.valid = s3_valid;

endmodule

// ===== src/dsag_checker.sv =====
module dsag_checker (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_req_valid,
    input  logic             i_req_ready,
    input  logic             i_res_valid,
    input  logic             i_res_ready,
    input  dsag_pkg::t_board i_res_attacks
);

    // A stalled result holds its value.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid && $stable(i_res_attacks))
        else $error("result changed while stalled");

    // A receiver that takes results never back-pressures the request side.
    a_ready_through: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_ready |-> i_req_ready)
        else $error("request side stalled while results are taken");

    // With the receiver ready throughout, an accepted request comes out as a valid result.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && i_req_ready && i_res_ready) ##1 i_res_ready ##1 i_res_ready
        |=> i_res_valid)
        else $error("result missing after pipeline latency");

    // Attacks never land off the board.
    a_on_board: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid |-> ((i_res_attacks & ~dsag_pkg::BOARD_MASK) == '0))
        else $error("attack bit off the board");

endmodule

bind diagonal_slider_attack_generator_unit dsag_checker u_dsag_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_req_valid   (i_req.valid),
    .i_req_ready   (i_req.ready),
    .i_res_valid   (o_res.valid),
    .i_res_ready   (o_res.ready),
    .i_res_attacks (o_res.attacks)
);

// ===== tb/sv/dsag_attack_checker.sv =====
`timescale 1ns / 100ps

// Watches the request and result channels of the bishop attack unit.
// It predicts the attack mask of every accepted request and compares each
// accepted result with the oldest prediction.
module dsag_attack_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    dsag_req_if  req,
    dsag_res_if  res,
    output int   o_fail_count,
    output int   o_pending
);

    // Row and column deltas per diagonal, indexed by the package directions.
    localparam int ROW_DELTA [dsag_pkg::NUM_DIRS] = '{-1, 1, 1, -1};
    localparam int COL_DELTA [dsag_pkg::NUM_DIRS] = '{1, 1, -1, -1};

    dsag_pkg::t_board attack_queue [$];
    dsag_pkg::t_board wanted_attacks;
    int               mismatch_count = 0;

    assign o_fail_count = mismatch_count;

    task automatic report_mismatch(input string msg);
        $display("%0t ns: mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    // Walks each diagonal from the origin and stops on the first occupied
    // square, which stays in the ray. Own squares are cleared at the end.
    function automatic dsag_pkg::t_board bishop_reach(input dsag_pkg::t_square sq,
                                                      input dsag_pkg::t_board occ,
                                                      input dsag_pkg::t_board own);
        dsag_pkg::t_board reach;
        int               row;
        int               col;
        int               r;
        int               c;
        bit               path_clear;
        reach = '0;
        if (int'(sq) < dsag_pkg::NUM_SQ) begin
            row = int'(sq) / dsag_pkg::BOARD_WIDTH;
            col = int'(sq) % dsag_pkg::BOARD_WIDTH;
            for (int d = 0; d < dsag_pkg::NUM_DIRS; d++) begin
                r          = row + ROW_DELTA[d];
                c          = col + COL_DELTA[d];
                path_clear = 1'b1;
                while (path_clear && r >= 0 && r < dsag_pkg::BOARD_WIDTH && c >= 0
                       && c < dsag_pkg::BOARD_WIDTH) begin
                    reach[r * dsag_pkg::BOARD_WIDTH + c] = 1'b1;
                    path_clear = !occ[r * dsag_pkg::BOARD_WIDTH + c];
                    r = r + ROW_DELTA[d];
                    c = c + COL_DELTA[d];
                end
            end
            reach = reach & ~own & dsag_pkg::BOARD_MASK;
        end
        return reach;
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (res.valid && res.ready) begin
                if (attack_queue.size() == 0) begin
                    report_mismatch($sformatf("attack mask %h with no request outstanding",
                                              res.attacks));
                end else begin
                    wanted_attacks = attack_queue.pop_front();
                    if (res.attacks !== wanted_attacks) begin
                        report_mismatch($sformatf("attacks %h, predicted %h",
                                                  res.attacks, wanted_attacks));
                    end
                end
            end
            if (req.valid && req.ready) begin
                attack_queue.push_back(bishop_reach(req.square, req.occupied,
                                                    req.own_pieces));
            end
        end
        o_pending <= attack_queue.size();
    end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps

// Top of the bench for the bishop attack unit. It drives requests, stalls
// the result side, and prints the verdict. All prediction and comparison
// lives in the checker instantiated beside the unit.
module tb;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    dsag_req_if req_bus ();
    dsag_res_if res_bus ();

    int fail_count;
    int pending;

    // Sender burst bookkeeping: requests left in the current burst.
    int burst_left = 0;

    // Cycle counter that drives the receiver's stall pattern.
    int stall_cycle = 0;

    dsag_pkg::t_square pos_square;
    dsag_pkg::t_board  pos_occupied;
    dsag_pkg::t_board  pos_own;

    diagonal_slider_attack_generator_unit DUT (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_bus),
        .o_res   (res_bus)
    );

    dsag_attack_checker checker_inst (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .req          (req_bus),
        .res          (res_bus),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // 8 ns clock period: four high, four low.
    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // The receiver cycles through four behaviors in equal stretches: always
    // ready, coin-flip ready, ready a quarter of the time, and long stalls
    // that keep ready low for five eighths of the time. The long stalls let
    // all three pipeline stages fill so the request side sees back pressure.
    always @(posedge clk) begin
        stall_cycle <= stall_cycle + 1;
        case ((stall_cycle / 256) % 4)
            0: begin
                res_bus.ready <= 1'b1;
            end
            1: begin
                res_bus.ready <= 1'($urandom_range(0, 1));
            end
            2: begin
                res_bus.ready <= (stall_cycle % 4 == 0);
            end
            default: begin
                res_bus.ready <= (stall_cycle % 32 >= 20);
            end
        endcase
    end

    // Puts one request on the channel and returns at the edge that accepts
    // it. Requests come in bursts of random length; between bursts the
    // sender goes quiet for a random gap, and a quarter of the time it
    // goes straight on with no gap at all.
    task automatic issue_request(input dsag_pkg::t_square sq, input dsag_pkg::t_board occ,
                                 input dsag_pkg::t_board own);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0) begin
                req_bus.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left = burst_left - 1;
        req_bus.valid      <= 1'b1;
        req_bus.square     <= sq;
        req_bus.occupied   <= occ;
        req_bus.own_pieces <= own;
        do @(posedge clk); while (!req_bus.ready);
    endtask

    // Stops sending and waits until every predicted result has come back.
    // The count from the checker is registered, so the task always waits on
    // a clock edge before it trusts the count.
    task automatic drain_results();
        req_bus.valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    function automatic dsag_pkg::t_board random_board();
        return {$urandom(), $urandom()};
    endfunction

    // Builds a random position. Most positions are plausible: the mover's
    // pieces are a subset of the occupancy and the origin square holds one
    // of them, with occupancy ranging from sparse to dense. The rest is
    // noise, where own squares need not be occupied at all, and boards that
    // are empty or hold a single blocker.
    task automatic roll_position(output dsag_pkg::t_square sq, output dsag_pkg::t_board occ,
                                 output dsag_pkg::t_board own);
        int kind;
        kind = $urandom_range(0, 9);
        sq   = dsag_pkg::t_square'($urandom_range(0, 63));
        case (kind)
            0, 1, 2, 3: begin
                occ = random_board() & random_board() & random_board();
            end
            4, 5, 6: begin
                occ = random_board() & random_board();
            end
            7, 8: begin
                occ = random_board();
            end
            default: begin
                occ = ($urandom_range(0, 1) == 0) ? '0
                    : (dsag_pkg::t_board'(1) << $urandom_range(0, 63));
            end
        endcase
        own = occ & random_board();
        if (kind == 8) begin
            own = random_board();
        end else if ($urandom_range(0, 3) != 0) begin
            // The bishop itself normally stands on its origin square.
            occ[sq] = 1'b1;
            own[sq] = 1'b1;
        end
    endtask

    initial begin
        // Request inputs of the unit are known before the first edge.
        req_bus.valid      = 1'b0;
        req_bus.square     = '0;
        req_bus.occupied   = '0;
        req_bus.own_pieces = '0;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: corners and center on an empty board, a full board
        // with and without own pieces, origin bits set in either mask, and
        // blockers at the near and far ends of the long diagonal.
        issue_request(dsag_pkg::t_square'(0),  '0, '0);
        issue_request(dsag_pkg::t_square'(7),  '0, '0);
        issue_request(dsag_pkg::t_square'(56), '0, '0);
        issue_request(dsag_pkg::t_square'(63), '0, '0);
        issue_request(dsag_pkg::t_square'(27), '0, '0);
        issue_request(dsag_pkg::t_square'(36), '1, '0);
        issue_request(dsag_pkg::t_square'(36), '1, '1);
        issue_request(dsag_pkg::t_square'(0),  '1, '0);
        issue_request(dsag_pkg::t_square'(35), '0, '1);
        issue_request(dsag_pkg::t_square'(63), dsag_pkg::t_board'(1) << 63,
                      dsag_pkg::t_board'(1) << 63);
        issue_request(dsag_pkg::t_square'(28), dsag_pkg::t_board'(1) << 28, '0);
        issue_request(dsag_pkg::t_square'(28), '0, dsag_pkg::t_board'(1) << 28);
        issue_request(dsag_pkg::t_square'(0),  64'h8040201008040201, '0);
        issue_request(dsag_pkg::t_square'(0),  dsag_pkg::t_board'(1) << 63, '0);
        issue_request(dsag_pkg::t_square'(0),  dsag_pkg::t_board'(1) << 63,
                      dsag_pkg::t_board'(1) << 63);
        // Blockers two steps out on the north-east, south-east and south-west
        // diagonals of square 27; the north-east and south-west ones are the mover's.
        issue_request(dsag_pkg::t_square'(27),
                      64'h0000_2200_0022_0000 | (dsag_pkg::t_board'(1) << 13)
                      | (dsag_pkg::t_board'(1) << 41),
                      (dsag_pkg::t_board'(1) << 13) | (dsag_pkg::t_board'(1) << 41));
        issue_request(dsag_pkg::t_square'(9), 64'h0000_0000_0000_0505,
                      64'h0000_0000_0000_0005);
        drain_results();

        // Random part, with one full drain halfway through.
        for (int n = 0; n < 900; n++) begin
            roll_position(pos_square, pos_occupied, pos_own);
            issue_request(pos_square, pos_occupied, pos_own);
            if (n == 450) begin
                drain_results();
            end
        end

        drain_results();
        repeat (12) @(posedge clk);

        if (fail_count == 0 && pending == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

    // Run limit, far above the slowest legal run.
    initial begin
        #4000000;
        $display("tb failed");
        $finish;
    end

endmodule

// ===== diagonal_slider_attack_generator_unit.f =====
src/dsag_pkg.sv
src/dsag_if.sv
src/dsag_ray_stage.sv
src/dsag_blocker_stage.sv
src/dsag_cut_stage.sv
src/diagonal_slider_attack_generator_unit.sv
src/dsag_checker.sv
tb/sv/dsag_attack_checker.sv
tb/sv/tb.sv
